[rtl/core/sedb_pkg.sv]
// ----------------------------------------------------------------------------
// sedb_pkg
// Shared constants, types and detector decode for the event detector bank.
// ----------------------------------------------------------------------------
package sedb_pkg;

    localparam int CHANNELS    = 16;
    localparam int DETECTORS   = 32;
    localparam int MAX_RESULTS = 32;

    localparam int CH_IDX_W  = $clog2(CHANNELS);
    localparam int DET_IDX_W = $clog2(DETECTORS);
    localparam int DET_CNT_W = $clog2(DETECTORS + 1);

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // op codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_FIRED = 2'd0;
    localparam logic [1:0] ST_ADDED = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // detector kinds
    localparam logic [3:0] KIND_LOGIC_CHANGE  = 4'd0;
    localparam logic [3:0] KIND_STATE_REACHED = 4'd1;
    localparam logic [3:0] KIND_ANALOG_CHANGE = 4'd2;
    localparam logic [3:0] KIND_CROSSING      = 4'd3;
    localparam logic [3:0] KIND_RISE          = 4'd4;
    localparam logic [3:0] KIND_FALL          = 4'd5;
    localparam logic [3:0] KIND_WIN_ENTER     = 4'd6;
    localparam logic [3:0] KIND_WIN_LEAVE     = 4'd7;
    localparam logic [3:0] KIND_ZERO          = 4'd8;
    localparam logic [3:0] KIND_SATURATION    = 4'd9;

    typedef struct packed {
        logic [3:0] channel;
        logic [3:0] kind;
        logic [7:0] level_a;
        logic [7:0] level_b;
    } det_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic start;       // input beat accepted
        logic step;        // advance table walk
        logic load_hit;    // capture current hit into pending slot
        logic push_pend;   // move pending slot to output register
        logic push_last;   // last flag for the pushed beat
        logic clear_pend;  // pending slot consumed
    } sedb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic pend_valid;
        logic out_free;
        logic issue_ok;
        logic ev_valid;
    } sedb_sts_t;

    function automatic logic lvl_rise(input logic [7:0] now, input logic [7:0] prev,
                                      input logic [7:0] lvl);
        return (now >= lvl) && (prev < lvl);
    endfunction

    function automatic logic lvl_fall(input logic [7:0] now, input logic [7:0] prev,
                                      input logic [7:0] lvl);
        return (now < lvl) && (prev >= lvl);
    endfunction

    function automatic logic in_window(input logic [7:0] v, input logic [7:0] lo,
                                       input logic [7:0] hi);
        return (v >= lo) && (v < hi);
    endfunction

    function automatic logic det_fires(input det_entry_t d, input logic [7:0] now,
                                       input logic [7:0] prev);
        logic f;
        f = 1'b0;
        case (d.kind) inside
            KIND_LOGIC_CHANGE, KIND_ANALOG_CHANGE: f = (now != prev);
            KIND_STATE_REACHED: f = (now != prev) && (now == d.level_a);
            KIND_CROSSING:  f = lvl_rise(now, prev, d.level_a) ||
                                lvl_fall(now, prev, d.level_a);
            KIND_RISE:      f = lvl_rise(now, prev, d.level_a);
            KIND_FALL:      f = lvl_fall(now, prev, d.level_a);
            KIND_WIN_ENTER: f = in_window(now, d.level_a, d.level_b) &&
                                !in_window(prev, d.level_a, d.level_b);
            KIND_WIN_LEAVE: f = lvl_fall(now, prev, d.level_a) ||
                                lvl_rise(now, prev, d.level_b);
            KIND_ZERO:       f = (now == 8'd0);
            KIND_SATURATION: f = (now == FULL_SCALE);
            default:         f = 1'b0;  // unknown kinds never fire
        endcase
        return f;
    endfunction

endpackage

[rtl/core/sedb_ctrl.sv]
// ----------------------------------------------------------------------------
// sedb_ctrl
// Sequencer: accepts input beats, runs the table walk, drains results.
// ----------------------------------------------------------------------------
module sedb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [3:0]          channel,
    input  sedb_pkg::sedb_sts_t sts,
    output sedb_pkg::sedb_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stall;
    logic       ch_ok;

    assign ch_ok    = (channel < sedb_pkg::CHANNELS);
    assign in_ready = (state_reg == S_IDLE);
    // a new hit needs the pending slot emptied first
    assign stall    = sts.hit && sts.pend_valid && !sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (op == sedb_pkg::OP_SAMPLE && ch_ok)
                        state_next = S_SCAN;
                    else if (op == sedb_pkg::OP_ADD)
                        state_next = S_DRAIN;
                end
            end
            S_SCAN:
            begin
                cmd.step      = !stall;
                cmd.load_hit  = sts.hit && !stall;
                cmd.push_pend = sts.hit && sts.pend_valid && sts.out_free;
                if (!sts.issue_ok && !sts.ev_valid)
                    state_next = sts.pend_valid ? S_DRAIN : S_IDLE;
            end
            S_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.push_pend  = 1'b1;
                    cmd.push_last  = 1'b1;
                    cmd.clear_pend = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/sedb_datapath.sv]
// ----------------------------------------------------------------------------
// sedb_datapath
// Channel history, detector table memory, walk pipeline and result register.
// ----------------------------------------------------------------------------
module sedb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sedb_pkg::sedb_cmd_t cmd,
    output sedb_pkg::sedb_sts_t sts,
    input  logic [1:0]          op,
    input  logic [3:0]          channel,
    input  logic [7:0]          sample,
    input  logic [3:0]          kind,
    input  logic [7:0]          level_a,
    input  logic [7:0]          level_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          detector_index,
    output logic [7:0]          value,
    output logic [31:0]         event_time,
    output logic [1:0]          status,
    output logic                last
);

    localparam int IW = sedb_pkg::DET_IDX_W;
    localparam int CW = sedb_pkg::DET_CNT_W;
    localparam int CH_IDX_W_L = sedb_pkg::CH_IDX_W;

    logic [7:0]             prev_val_reg [sedb_pkg::CHANNELS];
    sedb_pkg::det_entry_t   det_mem      [sedb_pkg::DETECTORS];
    sedb_pkg::det_entry_t   rd_data_reg;

    logic [CW-1:0]  det_count_reg;
    logic [31:0]    tick_reg;

    logic [3:0]     ch_reg;
    logic [7:0]     smp_reg;
    logic [7:0]     prev_reg;

    logic [CW-1:0]  scan_addr_reg;
    logic           ev_valid_reg;
    logic [IW-1:0]  ev_idx_reg;

    logic           pend_valid_reg;
    logic [4:0]     pend_idx_reg;
    logic [7:0]     pend_val_reg;
    logic [31:0]    pend_time_reg;
    logic [1:0]     pend_st_reg;

    logic           out_valid_reg;
    logic [4:0]     out_idx_reg;
    logic [7:0]     out_val_reg;
    logic [31:0]    out_time_reg;
    logic [1:0]     out_st_reg;
    logic           out_last_reg;

    logic           start_smp;
    logic           start_add;
    logic           table_full;
    logic           issue_ok;
    logic           rd_en;
    logic           hit;
    logic [CH_IDX_W_L-1:0] ch_idx;

    assign ch_idx     = channel[CH_IDX_W_L-1:0];
    assign start_smp  = cmd.start && (op == sedb_pkg::OP_SAMPLE) &&
                        (channel < sedb_pkg::CHANNELS);
    assign start_add  = cmd.start && (op == sedb_pkg::OP_ADD);
    assign table_full = (det_count_reg >= CW'(sedb_pkg::DETECTORS));
    assign issue_ok   = (scan_addr_reg < det_count_reg);
    assign rd_en      = cmd.step && issue_ok;
    assign hit        = ev_valid_reg && (rd_data_reg.channel == ch_reg) &&
                        sedb_pkg::det_fires(rd_data_reg, smp_reg, prev_reg);

    assign sts.hit        = hit;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.issue_ok   = issue_ok;
    assign sts.ev_valid   = ev_valid_reg;

    // per-channel history, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sedb_pkg::CHANNELS; i++)
                prev_val_reg[i] <= 8'd0;
        end
        else if (start_smp)
        begin
            prev_val_reg[ch_idx] <= sample;
        end
    end

    // detector table: one write port (add), one registered read port (walk)
    always_ff @(posedge clk)
    begin
        if (start_add && !table_full)
            det_mem[det_count_reg[IW-1:0]] <= {channel, kind, level_a, level_b};
        if (rd_en)
            rd_data_reg <= det_mem[scan_addr_reg[IW-1:0]];
    end

    // sample latch, no reset needed
    always_ff @(posedge clk)
    begin
        if (start_smp)
        begin
            ch_reg   <= channel;
            smp_reg  <= sample;
            prev_reg <= prev_val_reg[ch_idx];
        end
        if (rd_en)
            ev_idx_reg <= scan_addr_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_count_reg  <= '0;
            tick_reg       <= 32'd0;
            scan_addr_reg  <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start && op == sedb_pkg::OP_TICK)
                tick_reg <= tick_reg + 32'd1;
            if (start_add && !table_full)
                det_count_reg <= det_count_reg + CW'(1);

            if (start_smp)
            begin
                scan_addr_reg <= '0;
                ev_valid_reg  <= 1'b0;
            end
            else if (cmd.step)
            begin
                ev_valid_reg <= issue_ok;
                if (issue_ok)
                    scan_addr_reg <= scan_addr_reg + CW'(1);
            end

            if (cmd.start)
                pend_valid_reg <= start_add;
            else if (cmd.load_hit)
                pend_valid_reg <= 1'b1;
            else if (cmd.clear_pend)
                pend_valid_reg <= 1'b0;

            if (cmd.push_pend)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // pending slot and result register payload
    always_ff @(posedge clk)
    begin
        if (start_add)
        begin
            pend_idx_reg  <= table_full ? 5'd0 : det_count_reg[4:0];
            pend_val_reg  <= 8'd0;
            pend_time_reg <= tick_reg;
            pend_st_reg   <= table_full ? sedb_pkg::ST_FULL : sedb_pkg::ST_ADDED;
        end
        else if (cmd.load_hit)
        begin
            pend_idx_reg  <= 5'(ev_idx_reg);
            pend_val_reg  <= smp_reg;
            pend_time_reg <= tick_reg;
            pend_st_reg   <= sedb_pkg::ST_FIRED;
        end
        if (cmd.push_pend)
        begin
            out_idx_reg  <= pend_idx_reg;
            out_val_reg  <= pend_val_reg;
            out_time_reg <= pend_time_reg;
            out_st_reg   <= pend_st_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign detector_index = out_idx_reg;
    assign value          = out_val_reg;
    assign event_time     = out_time_reg;
    assign status         = out_st_reg;
    assign last           = out_last_reg;

endmodule

[rtl/core/sensor_event_detector_bank_core.sv]
// ----------------------------------------------------------------------------
// sensor_event_detector_bank_core
// Table of up to 32 threshold/window detectors over 16 sensor channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command: op 0 is a
//   sample for a channel, op 1 adds a detector, op 2 advances the tick time,
//   op 3 is dropped. in_ready is high only while the sequencer is idle.
//   Output channel (out_valid/out_ready) carries result beats; last marks the
//   final beat of the command. Adds give exactly one beat (added or full).
//   Ticks and quiet samples give none.
// Timing:
//   A tick leaves the sequencer idle; an add result passes through the pending
//   slot into the result register. A sample walks the detector table one entry
//   per cycle through the table memory's single read port, unless a firing
//   detector waits on a full result register. The block takes one command at a
//   time.
// Reset clears the channel history, detector count and tick time; table
//   entries are only valid once written. When the receiver stalls, the walk
//   holds on the next firing detector until the result register drains.
// ----------------------------------------------------------------------------
module sensor_event_detector_bank_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  channel,
    input  logic [7:0]  sample,
    input  logic [3:0]  kind,
    input  logic [7:0]  level_a,
    input  logic [7:0]  level_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  detector_index,
    output logic [7:0]  value,
    output logic [31:0] event_time,
    output logic [1:0]  status,
    output logic        last
);

    sedb_pkg::sedb_cmd_t cmd;
    sedb_pkg::sedb_sts_t sts;

    // sequencer: decides when to walk, when to push a beat, and the last flag
    sedb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .channel  (channel),
        .sts      (sts),
        .cmd      (cmd)
    );

    // storage and compare; one pending hit is held back so the last flag
    // can be set once the walk knows no later detector fires
    sedb_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .channel        (channel),
        .sample         (sample),
        .kind           (kind),
        .level_a        (level_a),
        .level_b        (level_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .detector_index (detector_index),
        .value          (value),
        .event_time     (event_time),
        .status         (status),
        .last           (last)
    );

    // idle sequencer never leaves a held-back result behind
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.pend_valid)
        else $error("pending result left while idle");

    // add/full results always close their command
    a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sedb_pkg::ST_FIRED) |-> last)
        else $error("add result without last");

    // add results carry a zero value
    a_add_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sedb_pkg::ST_ADDED) |-> (value == 8'd0))
        else $error("add result with nonzero value");

    // a walk blocked on a full result register keeps its hit
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && sts.hit && sts.pend_valid && !sts.out_free |=> sts.hit)
        else $error("hit lost during stall");

endmodule

[verif/sedb_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sedb_core_checker
// Watches both channels of the detector bank, predicts the result beats of
// every accepted command and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module sedb_core_checker
    import sedb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  channel,
    input  logic [7:0]  sample,
    input  logic [3:0]  kind,
    input  logic [7:0]  level_a,
    input  logic [7:0]  level_b,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  detector_index,
    input  logic [7:0]  value,
    input  logic [31:0] event_time,
    input  logic [1:0]  status,
    input  logic        last,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [4:0]  index;
        logic [7:0]  value;
        logic [31:0] stamp;
        logic [1:0]  status;
        logic        last;
    } report_t;

    report_t              due_reports[$];
    logic [7:0]           chan_history[CHANNELS];
    det_entry_t           det_table[DETECTORS];
    logic [DET_CNT_W-1:0] det_total;
    logic [31:0]          ticks;
    int                   bad_count;

    function automatic logic detector_trips(input det_entry_t d, input logic [7:0] now,
                                            input logic [7:0] prev);
        logic up_a, down_a, up_b, win_now, win_prev;
        up_a     = (now >= d.level_a) && (prev < d.level_a);
        down_a   = (now < d.level_a) && (prev >= d.level_a);
        up_b     = (now >= d.level_b) && (prev < d.level_b);
        win_now  = (now >= d.level_a) && (now < d.level_b);
        win_prev = (prev >= d.level_a) && (prev < d.level_b);
        case (d.kind)
            KIND_LOGIC_CHANGE, KIND_ANALOG_CHANGE: return now != prev;
            KIND_STATE_REACHED: return (now != prev) && (now == d.level_a);
            KIND_CROSSING:      return up_a || down_a;
            KIND_RISE:          return up_a;
            KIND_FALL:          return down_a;
            KIND_WIN_ENTER:     return win_now && !win_prev;
            KIND_WIN_LEAVE:     return down_a || up_b;
            KIND_ZERO:          return now == 8'd0;
            KIND_SATURATION:    return now == FULL_SCALE;
            default:            return 1'b0;
        endcase
    endfunction

    // Queues the beats one command yields and updates the shadow state.
    function automatic void predict_command(input logic [1:0] o, input logic [3:0] ch,
                                            input logic [7:0] smp, input logic [3:0] k,
                                            input logic [7:0] la, input logic [7:0] lb);
        logic [7:0] prev;
        int         hits;
        report_t    r;
        report_t    held;
        hits = 0;
        case (o)
            OP_SAMPLE:
            begin
                if (ch < CHANNELS)
                begin
                    prev = chan_history[ch];
                    chan_history[ch] = smp;
                    // hold back the newest hit so the final one can carry last
                    for (int i = 0; i < det_total && hits < MAX_RESULTS; i++)
                    begin
                        if (det_table[i].channel == ch && detector_trips(det_table[i], smp, prev))
                        begin
                            if (hits > 0)
                                due_reports.push_back(held);
                            held = {5'(i), smp, ticks, ST_FIRED, 1'b0};
                            hits++;
                        end
                    end
                    if (hits > 0)
                    begin
                        held.last = 1'b1;
                        due_reports.push_back(held);
                    end
                end
            end
            OP_ADD:
            begin
                if (det_total >= DETECTORS)
                    r = {5'd0, 8'd0, ticks, ST_FULL, 1'b1};
                else
                begin
                    det_table[det_total[DET_IDX_W-1:0]] = {ch, k, la, lb};
                    r = {det_total[4:0], 8'd0, ticks, ST_ADDED, 1'b1};
                    det_total = det_total + 1'b1;
                end
                due_reports.push_back(r);
            end
            OP_TICK: ticks = ticks + 32'd1;
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t seen;
        report_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
                chan_history[c] = 8'd0;
            det_total = '0;
            ticks     = 32'd0;
            bad_count = 0;
            due_reports.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // a beat leaving now belongs to an older command than one entering now
            if (out_valid && out_ready)
            begin
                seen = {detector_index, value, event_time, status, last};
                if (due_reports.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected beat: idx %0d value %0h time %0d status %0d last %0b",
                                 seen.index, seen.value, seen.stamp, seen.status, seen.last);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (seen !== want)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"mismatch (exp/got): idx %0d/%0d value %0h/%0h ",
                                      "time %0d/%0d status %0d/%0d last %0b/%0b"},
                                     want.index, seen.index, want.value, seen.value,
                                     want.stamp, seen.stamp, want.status, seen.status,
                                     want.last, seen.last);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_command(op, channel, sample, kind, level_a, level_b);
            mismatches  <= bad_count;
            outstanding <= due_reports.size();
        end
    end

endmodule

[verif/sensor_event_detector_bank_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_event_detector_bank_core_tb
// Drives commands into the detector bank and gives the verdict; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module sensor_event_detector_bank_core_tb;
    import sedb_pkg::*;

    // op 3 has no meaning; the block drops it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 140;
    localparam int TABLE_FILL    = 20;     // first random commands are adds
    localparam int HOLDOFF_BEATS = 400;    // long sink stall, in cycles
    localparam int DRAIN_CYCLES  = 80;     // > one full table walk
    localparam int LIMIT_NS      = 3_000_000;

    // idling profile of the current stretch of stimulus
    typedef enum logic [1:0] {
        PH_STEADY,       // no idling on either side
        PH_SPARSE_SEND,  // sender idle most cycles
        PH_SLOW_SINK,    // receiver stalls most cycles
        PH_MIXED         // both sides idle now and then
    } phase_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  op        = OP_TICK;
    logic [3:0]  channel   = 4'd0;
    logic [7:0]  sample    = 8'd0;
    logic [3:0]  kind      = 4'd0;
    logic [7:0]  level_a   = 8'd0;
    logic [7:0]  level_b   = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  detector_index;
    logic [7:0]  value;
    logic [31:0] event_time;
    logic [1:0]  status;
    logic        last;

    phase_t      phase      = PH_STEADY;
    logic        squeeze_go = 1'b0;   // asks the sink for its long stall
    int          fail_count;
    int          outstanding;

    // levels of every detector added so far; samples aim at them
    logic [7:0]  level_pool[$];

    sensor_event_detector_bank_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .channel        (channel),
        .sample         (sample),
        .kind           (kind),
        .level_a        (level_a),
        .level_b        (level_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .detector_index (detector_index),
        .value          (value),
        .event_time     (event_time),
        .status         (status),
        .last           (last)
    );

    sedb_core_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .channel        (channel),
        .sample         (sample),
        .kind           (kind),
        .level_a        (level_a),
        .level_b        (level_b),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .detector_index (detector_index),
        .value          (value),
        .event_time     (event_time),
        .status         (status),
        .last           (last),
        .mismatches     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offers one command and returns at the edge where it is accepted.
    // Valid is either kept high for the next beat or lowered during a gap,
    // never both in one step.
    task automatic issue_command(input logic [1:0] o, input logic [3:0] ch,
                                 input logic [7:0] smp, input logic [3:0] k,
                                 input logic [7:0] la, input logic [7:0] lb);
        int idle_pct;
        case (phase)
            PH_SPARSE_SEND: idle_pct = 87;
            PH_MIXED:       idle_pct = 29;
            default:        idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        channel  <= ch;
        sample   <= smp;
        kind     <= k;
        level_a  <= la;
        level_b  <= lb;
        if (o == OP_ADD)
        begin
            level_pool.push_back(la);
            level_pool.push_back(lb);
        end
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Receiver side: random stalls per phase, plus one long hold-off once the
    // stimulus asks for it. The sender keeps offering meanwhile, so the walk
    // blocks on a full result register and in_ready drops.
    initial
    begin : sink_side
        int holdoff;
        int stall_pct;
        holdoff = -1;
        forever
        begin
            @(posedge clk);
            case (phase)
                PH_SLOW_SINK: stall_pct = 87;
                PH_MIXED:     stall_pct = 29;
                default:      stall_pct = 0;
            endcase
            if (squeeze_go && holdoff < 0)
                holdoff = HOLDOFF_BEATS;
            if (holdoff > 0)
            begin
                holdoff = holdoff - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : stimulus
        int         n;
        int         roll;
        int         pick;
        logic [3:0] ch;
        logic [3:0] k;
        logic [7:0] smp;
        logic [7:0] aim;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // tick before anything else, then the dropped op
        issue_command(OP_TICK, 4'($urandom), 8'($urandom), 4'($urandom),
                      8'($urandom), 8'($urandom));
        issue_command(OP_UNUSED, 4'($urandom), 8'($urandom), 4'($urandom),
                      8'($urandom), 8'($urandom));
        // sample with an empty table: quiet, but the reading is kept
        issue_command(OP_SAMPLE, 4'd0, 8'h00, 4'($urandom), 8'($urandom), 8'($urandom));

        // one detector of each known kind on channel 0
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_LOGIC_CHANGE, 8'($urandom), 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_STATE_REACHED, 8'hA5, 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_ANALOG_CHANGE, 8'($urandom), 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_CROSSING, 8'h80, 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_RISE, 8'h80, 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_FALL, 8'h80, 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_WIN_ENTER, 8'h40, 8'hC0);
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_WIN_LEAVE, 8'h40, 8'hC0);
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_ZERO, 8'($urandom), 8'($urandom));
        issue_command(OP_ADD, 4'd0, 8'($urandom), KIND_SATURATION, 8'($urandom), 8'($urandom));
        // unknown kinds are stored but stay silent; levels at both extremes
        issue_command(OP_ADD, 4'd15, 8'($urandom), 4'd15, 8'hFF, 8'hFF);
        issue_command(OP_ADD, 4'd0, 8'($urandom), 4'd10, 8'h00, 8'h00);

        // full-scale step on channel 0, then back through the levels
        issue_command(OP_SAMPLE, 4'd0, 8'hFF, 4'($urandom), 8'($urandom), 8'($urandom));
        issue_command(OP_TICK, 4'($urandom), 8'($urandom), 4'($urandom),
                      8'($urandom), 8'($urandom));
        issue_command(OP_SAMPLE, 4'd0, 8'hA5, 4'($urandom), 8'($urandom), 8'($urandom));
        // same reading again: nothing moves, so nothing fires
        issue_command(OP_SAMPLE, 4'd0, 8'hA5, 4'($urandom), 8'($urandom), 8'($urandom));
        issue_command(OP_SAMPLE, 4'd0, 8'h00, 4'($urandom), 8'($urandom), 8'($urandom));
        // channel with only an unknown kind, and one with no detector at all
        issue_command(OP_SAMPLE, 4'd15, 8'hFF, 4'($urandom), 8'($urandom), 8'($urandom));
        issue_command(OP_SAMPLE, 4'd5, 8'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));

        // ---- long sink stall with the sender pushing ----
        squeeze_go <= 1'b1;
        issue_command(OP_SAMPLE, 4'd0, 8'hFF, 4'($urandom), 8'($urandom), 8'($urandom));
        issue_command(OP_SAMPLE, 4'd0, 8'h00, 4'($urandom), 8'($urandom), 8'($urandom));

        // ---- random part ----
        // Fill the table first so most samples walk a full table, then a mix
        // of samples aimed at the stored levels, ticks, adds past full and noise.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            phase <= phase_t'(n * 4 / RANDOM_ITEMS);
            roll = $urandom_range(99);
            ch = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(3));
            k  = ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(9));
            if (n >= TABLE_FILL && roll < 4)
                issue_command(OP_UNUSED, 4'($urandom), 8'($urandom), 4'($urandom),
                              8'($urandom), 8'($urandom));
            else
            begin
                if (n < TABLE_FILL || roll < 12)
                    issue_command(OP_ADD, ch, 8'($urandom), k, 8'($urandom), 8'($urandom));
                else if (roll < 26)
                    issue_command(OP_TICK, 4'($urandom), 8'($urandom), 4'($urandom),
                                  8'($urandom), 8'($urandom));
                else
                begin
                    pick = $urandom_range(9);
                    aim  = level_pool[$urandom_range(level_pool.size() - 1)];
                    case (pick)
                        0:       smp = 8'h00;
                        1:       smp = 8'hFF;
                        2, 3:    smp = aim;
                        4:       smp = aim - 8'd1;
                        5:       smp = aim + 8'd1;
                        default: smp = 8'($urandom);
                    endcase
                    issue_command(OP_SAMPLE, ch, smp, 4'($urandom), 8'($urandom),
                                  8'($urandom));
                end
                n++;
            end
        end

        // ---- drain and verdict ----
        in_valid <= 1'b0;
        phase    <= PH_STEADY;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("sensor_event_detector_bank_core_tb OK");
        else
            $display("sensor_event_detector_bank_core_tb NOT OK");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("sensor_event_detector_bank_core_tb NOT OK");
        $finish;
    end

endmodule
